// File: rtl/spt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the servo position controller.
// No dependencies; used by spt_alu, spt_pid and the top level.
package spt_pkg;

	// Fixed controller constants
	localparam int MIN_STEP_MS    = 10;
	localparam int INTEGRAL_LIMIT = 1000;
	localparam int ADC_BITS       = 10;

	localparam int READ_W = 10;
	localparam logic [READ_W-1:0] ADC_MASK = READ_W'((64'd1 << ADC_BITS) - 64'd1);

	// Integral is held in position-milliseconds
	localparam int INTEG_LIM = INTEGRAL_LIMIT * 1000;
	localparam int INTEG_W   = $clog2(INTEG_LIM + 1) + 1;

	// Datapath of the shared unit: signed multiplier operands and accumulator
	localparam int MUL_W = 33;
	localparam int ACC_W = 56;
	localparam int LO_W  = 16;

	localparam int KP_SCALE  = 1000;
	localparam int KD_SCALE  = 1000000;
	localparam int DEN_SCALE = 256000;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [2:0] {
		REG_PROP_GAIN,
		REG_INTEG_GAIN,
		REG_DERIV_GAIN,
		REG_DEAD_ZONE,
		REG_LOWEST_POS,
		REG_HIGHEST_POS,
		REG_CURRENT_CEIL,
		REG_SUPPLY_WINDOW
	} cfg_reg_t;

	localparam logic [1:0] TRIP_NONE    = 2'd0;
	localparam logic [1:0] TRIP_CURRENT = 2'd1;
	localparam logic [1:0] TRIP_SUPPLY  = 2'd2;

	localparam logic [1:0] DIR_STOP    = 2'd0;
	localparam logic [1:0] DIR_FORWARD = 2'd1;
	localparam logic [1:0] DIR_REVERSE = 2'd2;

	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
	} gains_t;

	typedef struct packed {
		logic                      done;
		logic signed [8:0]         speed;
		logic signed [INTEG_W-1:0] integ;
	} pid_res_t;

endpackage

// File: rtl/servo_position_pid_with_safety_trip.sv
`timescale 1ns / 1ps
// Top level of the servo position controller: handshakes, configuration,
// power/control edges, target clamp, safety trip. Depends on spt_pkg, spt_pid.

// Takes one sample per input transaction and returns one status transaction
// for it. A sample that runs no PID step goes from capture through ST_EVAL to
// ST_EMIT; a sample that runs a PID step also passes through ST_BUSY. The step
// is 14 multiply, add and subtract operations on one shared multiplier-adder,
// then a restoring divide of up to 9 quotient bits, and in_ready stays low
// until the result is loaded into the output register. A finished result waits
// in the output register while the next sample is accepted. Configuration
// writes are taken at any time and should be made while no sample is in flight.
module servo_position_pid_with_safety_trip (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       elapsed_ms,
	input  logic [9:0]        position_reading,
	input  logic [9:0]        current_reading,
	input  logic [9:0]        supply_reading,
	input  logic [9:0]        target_request,
	input  logic              control_request,
	input  logic              power_request,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [8:0] drive_speed,
	output logic [1:0]        drive_direction,
	output logic [7:0]        drive_duty,
	output logic              powered,
	output logic              loop_active,
	output logic [1:0]        trip_cause,
	output logic signed [10:0] position_error,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [19:0]       cfg_data
);

	localparam int IW = spt_pkg::INTEG_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_BUSY,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [9:0]  dead_zone_q, lowest_q, highest_q, ceiling_q;
	logic [19:0] window_q;

	// controller state
	logic                  power_q, loop_q, prior_pwr_q, prior_ctl_q;
	logic [9:0]            held_target_q;
	logic signed [IW-1:0]  integ_q;
	logic signed [10:0]    prev_err_q;
	logic [15:0]           tss_q;
	logic signed [8:0]     speed_q;
	logic [1:0]            trip_q;

	// captured sample
	logic [15:0] elapsed_q;
	logic [9:0]  pos_q, cur_q, sup_q, req_q;
	logic        ctl_q, pwr_q;

	logic signed [10:0] err_q;
	logic [15:0]        dt_q;
	logic               start_q;

	// output register
	logic              out_valid_q;
	logic signed [8:0] drive_speed_q;
	logic [1:0]        drive_dir_q;
	logic [7:0]        drive_duty_q;
	logic              powered_q, loop_active_q;
	logic [1:0]        trip_out_q;
	logic signed [10:0] pos_err_q;

	// next-state values for one sample
	logic [16:0]          tss_sum;
	logic [15:0]          nx_tss, step_dt;
	logic                 nx_power, nx_loop, just_on, run_step, launch;
	logic signed [8:0]    nx_speed;
	logic [1:0]           nx_trip;
	logic signed [IW-1:0] nx_integ;
	logic signed [10:0]   nx_prev, err;
	logic [9:0]           tgt, pos_m, cur_m, sup_m;
	logic [10:0]          err_abs;
	logic [8:0]           spd_abs;

	spt_pkg::gains_t   gains;
	spt_pkg::pid_res_t pid_res;

	assign gains.kp = prop_gain_q;
	assign gains.ki = integ_gain_q;
	assign gains.kd = deriv_gain_q;

	spt_pid u_pid (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.err    (err_q),
		.prev   (prev_err_q),
		.dt     (dt_q),
		.integ  (integ_q),
		.gains  (gains),
		.res    (pid_res)
	);

	always_comb begin
		pos_m = pos_q & spt_pkg::ADC_MASK;
		cur_m = cur_q & spt_pkg::ADC_MASK;
		sup_m = sup_q & spt_pkg::ADC_MASK;

		tss_sum  = {1'b0, tss_q} + {1'b0, elapsed_q};
		nx_tss   = tss_q;
		if (power_q && loop_q) begin
			nx_tss = tss_sum[16] ? 16'hFFFF : tss_sum[15:0];
		end
		nx_power = power_q;
		nx_loop  = loop_q;
		nx_speed = speed_q;
		nx_trip  = trip_q;
		nx_integ = integ_q;
		nx_prev  = prev_err_q;
		just_on  = 1'b0;

		if (pwr_q && !prior_pwr_q) begin
			if (!power_q) begin
				nx_power = 1'b1;
				nx_trip  = spt_pkg::TRIP_NONE;
			end
		end else if (!pwr_q && prior_pwr_q) begin
			nx_power = 1'b0;
			nx_loop  = 1'b0;
			nx_speed = '0;
		end

		if (ctl_q && !prior_ctl_q) begin
			if (nx_power) begin
				nx_loop  = 1'b1;
				nx_integ = '0;
				nx_prev  = '0;
				nx_tss   = '0;
				just_on  = 1'b1;
			end
		end else if (!ctl_q && prior_ctl_q) begin
			nx_loop  = 1'b0;
			nx_speed = '0;
		end

		// low bound wins for low requests when the bounds cross
		if (req_q < lowest_q) begin
			tgt = lowest_q;
		end else if (req_q > highest_q) begin
			tgt = highest_q;
		end else begin
			tgt = req_q;
		end
		if (tgt != held_target_q) begin
			nx_integ = '0;
		end

		if (nx_power) begin
			if (cur_m > ceiling_q) begin
				nx_trip  = spt_pkg::TRIP_CURRENT;
				nx_power = 1'b0;
				nx_loop  = 1'b0;
				nx_speed = '0;
			end else if (sup_m < window_q[9:0] || sup_m > window_q[19:10]) begin
				nx_trip  = spt_pkg::TRIP_SUPPLY;
				nx_power = 1'b0;
				nx_loop  = 1'b0;
				nx_speed = '0;
			end
		end

		err     = $signed({1'b0, tgt}) - $signed({1'b0, pos_m});
		err_abs = err[10] ? 11'(-err) : 11'(err);

		step_dt  = nx_tss;
		run_step = nx_power && nx_loop && !just_on && (nx_tss >= 16'(spt_pkg::MIN_STEP_MS));
		launch   = 1'b0;
		if (run_step) begin
			nx_tss = '0;
			if (err_abs < {1'b0, dead_zone_q}) begin
				nx_speed = '0;
			end else begin
				launch = 1'b1;
			end
		end

		spd_abs = speed_q[8] ? 9'(-speed_q) : 9'(speed_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prop_gain_q   <= 16'd256;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			dead_zone_q   <= 10'd5;
			lowest_q      <= '0;
			highest_q     <= 10'd1023;
			ceiling_q     <= 10'd102;
			window_q      <= 20'd1047552;
			power_q       <= 1'b0;
			loop_q        <= 1'b0;
			prior_pwr_q   <= 1'b0;
			prior_ctl_q   <= 1'b0;
			held_target_q <= 10'd512;
			integ_q       <= '0;
			prev_err_q    <= '0;
			tss_q         <= '0;
			speed_q       <= '0;
			trip_q        <= spt_pkg::TRIP_NONE;
			elapsed_q     <= '0;
			pos_q         <= '0;
			cur_q         <= '0;
			sup_q         <= '0;
			req_q         <= '0;
			ctl_q         <= 1'b0;
			pwr_q         <= 1'b0;
			err_q         <= '0;
			dt_q          <= '0;
			start_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			drive_speed_q <= '0;
			drive_dir_q   <= spt_pkg::DIR_STOP;
			drive_duty_q  <= '0;
			powered_q     <= 1'b0;
			loop_active_q <= 1'b0;
			trip_out_q    <= spt_pkg::TRIP_NONE;
			pos_err_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					spt_pkg::REG_PROP_GAIN:     prop_gain_q  <= cfg_data[15:0];
					spt_pkg::REG_INTEG_GAIN:    integ_gain_q <= cfg_data[15:0];
					spt_pkg::REG_DERIV_GAIN:    deriv_gain_q <= cfg_data[15:0];
					spt_pkg::REG_DEAD_ZONE:     dead_zone_q  <= cfg_data[9:0];
					spt_pkg::REG_LOWEST_POS:    lowest_q     <= cfg_data[9:0];
					spt_pkg::REG_HIGHEST_POS:   highest_q    <= cfg_data[9:0];
					spt_pkg::REG_CURRENT_CEIL:  ceiling_q    <= cfg_data[9:0];
					spt_pkg::REG_SUPPLY_WINDOW: window_q     <= cfg_data;
					default: ;
				endcase
			end

			// in ST_EMIT the output register is reloaded below instead
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						elapsed_q <= elapsed_ms;
						pos_q     <= position_reading;
						cur_q     <= current_reading;
						sup_q     <= supply_reading;
						req_q     <= target_request;
						ctl_q     <= control_request;
						pwr_q     <= power_request;
						state_q   <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					power_q       <= nx_power;
					loop_q        <= nx_loop;
					prior_pwr_q   <= pwr_q;
					prior_ctl_q   <= ctl_q;
					held_target_q <= tgt;
					integ_q       <= nx_integ;
					prev_err_q    <= nx_prev;
					tss_q         <= nx_tss;
					speed_q       <= nx_speed;
					trip_q        <= nx_trip;
					err_q         <= err;
					dt_q          <= step_dt;
					start_q       <= launch;
					state_q       <= launch ? ST_BUSY : ST_EMIT;
				end
				ST_BUSY: begin
					start_q <= 1'b0;
					if (pid_res.done) begin
						speed_q    <= pid_res.speed;
						integ_q    <= pid_res.integ;
						prev_err_q <= err_q;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						drive_speed_q <= speed_q;
						drive_duty_q  <= spd_abs[7:0];
						if (speed_q[8]) begin
							drive_dir_q <= spt_pkg::DIR_REVERSE;
						end else if (speed_q != 9'sd0) begin
							drive_dir_q <= spt_pkg::DIR_FORWARD;
						end else begin
							drive_dir_q <= spt_pkg::DIR_STOP;
						end
						powered_q     <= power_q;
						loop_active_q <= loop_q;
						trip_out_q    <= trip_q;
						pos_err_q     <= err_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign drive_speed     = drive_speed_q;
	assign drive_direction = drive_dir_q;
	assign drive_duty      = drive_duty_q;
	assign powered         = powered_q;
	assign loop_active     = loop_active_q;
	assign trip_cause      = trip_out_q;
	assign position_error  = pos_err_q;

endmodule

// File: rtl/spt_alu.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: signed multiply, add or subtract, result registered.
// Depends on spt_pkg.
module spt_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  spt_pkg::alu_op_t  op,
	input  spt_pkg::acc_t     a,
	input  spt_pkg::acc_t     b,
	output spt_pkg::acc_t     res
);

	logic signed [2*spt_pkg::MUL_W-1:0] prod;
	spt_pkg::acc_t                      res_d;
	spt_pkg::acc_t                      res_q;

	always_comb begin
		prod  = $signed(a[spt_pkg::MUL_W-1:0]) * $signed(b[spt_pkg::MUL_W-1:0]);
		case (op)
			spt_pkg::ALU_MUL: res_d = prod[spt_pkg::ACC_W-1:0];
			spt_pkg::ALU_ADD: res_d = a + b;
			spt_pkg::ALU_SUB: res_d = a - b;
			default:          res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

// File: rtl/spt_pid.sv
`timescale 1ns / 1ps
// PID step sequencer: integral update, gain products and a restoring divide,
// all through one shared spt_alu. Depends on spt_pkg and spt_alu.
module spt_pid (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [10:0]                err,
	input  logic signed [10:0]                prev,
	input  logic [15:0]                       dt,
	input  logic signed [spt_pkg::INTEG_W-1:0] integ,
	input  spt_pkg::gains_t                   gains,
	output spt_pkg::pid_res_t                 res
);

	localparam int ACC_W = spt_pkg::ACC_W;
	localparam logic [3:0] DIV_TOP = 4'd8;
	localparam spt_pkg::acc_t LIM_HI = ACC_W'(spt_pkg::INTEG_LIM);
	localparam spt_pkg::acc_t LIM_LO = -LIM_HI;

	typedef enum logic [4:0] {
		P_IDLE, P_DEN, P_IMUL, P_IADD, P_KPE, P_KP1K, P_KII, P_ASUM, P_AHI,
		P_ALO, P_ADTSUM, P_KDE, P_KD1M, P_NUM, P_ABS, P_SEL, P_DSUB, P_DCHK, P_DONE
	} pstate_t;

	pstate_t                           state_q;
	spt_pkg::alu_op_t                  op;
	spt_pkg::acc_t                     op_a;
	spt_pkg::acc_t                     op_b;
	spt_pkg::acc_t                     alu_res;
	spt_pkg::acc_t                     den_q;
	spt_pkg::acc_t                     acc_q;
	spt_pkg::acc_t                     rem_q;
	logic                              neg_q;
	logic [3:0]                        cnt_q;
	logic [7:0]                        quo_q;
	logic signed [spt_pkg::INTEG_W-1:0] integ_new_q;
	logic signed [spt_pkg::INTEG_W-1:0] integ_clamped;
	logic signed [11:0]                de;
	logic signed [8:0]                 quo_s;

	spt_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.a      (op_a),
		.b      (op_b),
		.res    (alu_res)
	);

	assign de = 12'(err) - 12'(prev);

	always_comb begin
		if (alu_res > LIM_HI) begin
			integ_clamped = spt_pkg::INTEG_W'(LIM_HI);
		end else if (alu_res < LIM_LO) begin
			integ_clamped = spt_pkg::INTEG_W'(LIM_LO);
		end else begin
			integ_clamped = spt_pkg::INTEG_W'(alu_res);
		end
	end

	// Each state issues one op; its result is read in the following state.
	always_comb begin
		op   = spt_pkg::ALU_ADD;
		op_a = '0;
		op_b = '0;
		case (state_q)
			P_DEN: begin
				op = spt_pkg::ALU_MUL; op_a = ACC_W'(dt); op_b = ACC_W'(spt_pkg::DEN_SCALE);
			end
			P_IMUL: begin
				op = spt_pkg::ALU_MUL; op_a = ACC_W'(err); op_b = ACC_W'(dt);
			end
			P_IADD: begin
				op = spt_pkg::ALU_ADD; op_a = ACC_W'(integ); op_b = alu_res;
			end
			P_KPE: begin
				op = spt_pkg::ALU_MUL; op_a = ACC_W'(gains.kp); op_b = ACC_W'(err);
			end
			P_KP1K: begin
				op = spt_pkg::ALU_MUL; op_a = alu_res; op_b = ACC_W'(spt_pkg::KP_SCALE);
			end
			P_KII: begin
				op = spt_pkg::ALU_MUL; op_a = ACC_W'(gains.ki); op_b = ACC_W'(integ_new_q);
			end
			P_ASUM: begin
				op = spt_pkg::ALU_ADD; op_a = acc_q; op_b = alu_res;
			end
			P_AHI: begin
				// upper part of (Kp*e*1000 + Ki*I), times dt
				op = spt_pkg::ALU_MUL; op_a = alu_res >>> spt_pkg::LO_W; op_b = ACC_W'(dt);
			end
			P_ALO: begin
				op = spt_pkg::ALU_MUL; op_a = ACC_W'(acc_q[spt_pkg::LO_W-1:0]);
				op_b = ACC_W'(dt);
			end
			P_ADTSUM: begin
				op = spt_pkg::ALU_ADD; op_a = acc_q; op_b = alu_res;
			end
			P_KDE: begin
				op = spt_pkg::ALU_MUL; op_a = ACC_W'(gains.kd); op_b = ACC_W'(de);
			end
			P_KD1M: begin
				op = spt_pkg::ALU_MUL; op_a = alu_res; op_b = ACC_W'(spt_pkg::KD_SCALE);
			end
			P_NUM: begin
				op = spt_pkg::ALU_ADD; op_a = acc_q; op_b = alu_res;
			end
			P_ABS: begin
				op = spt_pkg::ALU_SUB; op_a = '0; op_b = alu_res;
			end
			P_DSUB: begin
				op = spt_pkg::ALU_SUB; op_a = rem_q; op_b = den_q << cnt_q;
			end
			default: begin
				op = spt_pkg::ALU_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= P_IDLE;
			den_q       <= '0;
			acc_q       <= '0;
			rem_q       <= '0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			quo_q       <= '0;
			integ_new_q <= '0;
		end else begin
			case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q <= P_DEN;
					end
				end
				P_DEN:  state_q <= P_IMUL;
				P_IMUL: begin
					den_q   <= alu_res;
					state_q <= P_IADD;
				end
				P_IADD: state_q <= P_KPE;
				P_KPE: begin
					integ_new_q <= integ_clamped;
					state_q     <= P_KP1K;
				end
				P_KP1K: state_q <= P_KII;
				P_KII: begin
					acc_q   <= alu_res;
					state_q <= P_ASUM;
				end
				P_ASUM: state_q <= P_AHI;
				P_AHI: begin
					acc_q   <= alu_res;
					state_q <= P_ALO;
				end
				P_ALO: begin
					acc_q   <= alu_res <<< spt_pkg::LO_W;
					state_q <= P_ADTSUM;
				end
				P_ADTSUM: state_q <= P_KDE;
				P_KDE: begin
					acc_q   <= alu_res;
					state_q <= P_KD1M;
				end
				P_KD1M: state_q <= P_NUM;
				P_NUM:  state_q <= P_ABS;
				P_ABS: begin
					neg_q   <= alu_res[ACC_W-1];
					rem_q   <= alu_res;
					state_q <= P_SEL;
				end
				P_SEL: begin
					if (neg_q) begin
						rem_q <= alu_res;
					end
					cnt_q   <= DIV_TOP;
					quo_q   <= '0;
					state_q <= P_DSUB;
				end
				P_DSUB: state_q <= P_DCHK;
				P_DCHK: begin
					if (!alu_res[ACC_W-1]) begin
						rem_q <= alu_res;
					end
					if (cnt_q == DIV_TOP) begin
						// quotient of 256 or more saturates
						if (!alu_res[ACC_W-1]) begin
							quo_q   <= '1;
							state_q <= P_DONE;
						end else begin
							cnt_q   <= cnt_q - 4'd1;
							state_q <= P_DSUB;
						end
					end else begin
						quo_q[cnt_q[2:0]] <= !alu_res[ACC_W-1];
						if (cnt_q == 4'd0) begin
							state_q <= P_DONE;
						end else begin
							cnt_q   <= cnt_q - 4'd1;
							state_q <= P_DSUB;
						end
					end
				end
				P_DONE:  state_q <= P_IDLE;
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign quo_s     = $signed({1'b0, quo_q});
	assign res.done  = (state_q == P_DONE);
	assign res.speed = neg_q ? -quo_s : quo_s;
	assign res.integ = integ_new_q;

endmodule

// File: tb/tb_servo_position_pid_with_safety_trip.sv
`timescale 1ns / 1ps
// Self-checking testbench for servo_position_pid_with_safety_trip.
// Holds its own PID, edge and trip predictor; drives samples and register writes
// over valid/ready channels. Depends on spt_pkg and the RTL top level.
module tb_servo_position_pid_with_safety_trip;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [15:0] elapsed;
		logic [9:0]  pos;
		logic [9:0]  cur;
		logic [9:0]  sup;
		logic [9:0]  tgt;
		logic        ctl;
		logic        pwr;
	} sample_t;

	typedef struct packed {
		logic signed [8:0]  speed;
		logic [1:0]         dir;
		logic [7:0]         duty;
		logic               pwr;
		logic               loop;
		logic [1:0]         trip;
		logic signed [10:0] err;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] elapsed_ms = '0;
	logic [9:0] position_reading = '0;
	logic [9:0] current_reading = '0;
	logic [9:0] supply_reading = '0;
	logic [9:0] target_request = '0;
	logic control_request = 1'b0;
	logic power_request = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [8:0] drive_speed;
	logic [1:0] drive_direction;
	logic [7:0] drive_duty;
	logic powered;
	logic loop_active;
	logic [1:0] trip_cause;
	logic signed [10:0] position_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	servo_position_pid_with_safety_trip DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.elapsed_ms(elapsed_ms),
		.position_reading(position_reading),
		.current_reading(current_reading),
		.supply_reading(supply_reading),
		.target_request(target_request),
		.control_request(control_request),
		.power_request(power_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_speed(drive_speed),
		.drive_direction(drive_direction),
		.drive_duty(drive_duty),
		.powered(powered),
		.loop_active(loop_active),
		.trip_cause(trip_cause),
		.position_error(position_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Register shadow, reset values
	int kp_q = 256, ki_q = 0, kd_q = 0, dz_q = 5;
	int lo_q = 0, hi_q = 1023, ceil_q = 102, win_q = 1047552;

	// Controller shadow state
	bit motor_on = 0, loop_on = 0, pwr_lvl_q = 0, ctl_lvl_q = 0;
	int held_tgt = 512;
	longint integ_ms = 0;
	int prev_err = 0;
	int since_step_ms = 0;
	int speed_cmd = 0;
	logic [1:0] trip_q = spt_pkg::TRIP_NONE;

	sample_t sample_q[$];
	status_t status_q[$];
	sample_t on_bus;
	status_t want_stat;
	bit no_idle = 0;
	int items_queued = 0, items_taken = 0, results_checked = 0, mismatches = 0;
	int pid_steps = 0, sat_steps = 0, trips_seen = 0, cfg_writes = 0;
	int cycle_count = 0;

	function automatic void drop_power();
		motor_on = 0;
		loop_on = 0;
		speed_cmd = 0;
	endfunction

	// Advances the shadow controller by one sample and returns its status
	function automatic status_t servo_step(sample_t s);
		status_t r;
		bit fresh_loop;
		int tgt, err, aerr, dt;
		longint num, quo;
		fresh_loop = 0;

		if (motor_on && loop_on)
			since_step_ms = (since_step_ms + s.elapsed > 65535) ? 65535
				: since_step_ms + s.elapsed;

		if (s.pwr && !pwr_lvl_q) begin
			if (!motor_on) begin
				motor_on = 1;
				trip_q = spt_pkg::TRIP_NONE;
			end
		end else if (!s.pwr && pwr_lvl_q) begin
			drop_power();
		end
		pwr_lvl_q = s.pwr;

		if (s.ctl && !ctl_lvl_q) begin
			if (motor_on) begin
				loop_on = 1;
				integ_ms = 0;
				prev_err = 0;
				since_step_ms = 0;
				fresh_loop = 1;
			end
		end else if (!s.ctl && ctl_lvl_q) begin
			loop_on = 0;
			speed_cmd = 0;
		end
		ctl_lvl_q = s.ctl;

		// lowest bound wins when the bounds cross and the request is low
		tgt = int'(s.tgt);
		if (tgt < lo_q)
			tgt = lo_q;
		else if (tgt > hi_q)
			tgt = hi_q;
		if (tgt != held_tgt) begin
			held_tgt = tgt;
			integ_ms = 0;
		end

		if (motor_on) begin
			if (int'(s.cur) > ceil_q) begin
				trip_q = spt_pkg::TRIP_CURRENT;
				drop_power();
				trips_seen++;
			end else if (int'(s.sup) < win_q % 1024 || int'(s.sup) > win_q / 1024) begin
				trip_q = spt_pkg::TRIP_SUPPLY;
				drop_power();
				trips_seen++;
			end
		end

		err = held_tgt - int'(s.pos);

		if (motor_on && loop_on && !fresh_loop && since_step_ms >= spt_pkg::MIN_STEP_MS) begin
			dt = since_step_ms;
			since_step_ms = 0;
			aerr = err < 0 ? -err : err;
			if (aerr < dz_q) begin
				speed_cmd = 0;
			end else begin
				integ_ms += longint'(err) * dt;
				if (integ_ms > longint'(spt_pkg::INTEGRAL_LIMIT) * 1000)
					integ_ms = longint'(spt_pkg::INTEGRAL_LIMIT) * 1000;
				if (integ_ms < -longint'(spt_pkg::INTEGRAL_LIMIT) * 1000)
					integ_ms = -longint'(spt_pkg::INTEGRAL_LIMIT) * 1000;
				num = longint'(kp_q) * err * 1000 * dt
					+ longint'(ki_q) * integ_ms * dt
					+ longint'(kd_q) * (err - prev_err) * 1000000;
				prev_err = err;
				quo = num / (longint'(256000) * dt);
				if (quo > 255 || quo < -255)
					sat_steps++;
				if (quo > 255)
					quo = 255;
				if (quo < -255)
					quo = -255;
				speed_cmd = int'(quo);
				pid_steps++;
			end
		end

		r.speed = 9'(speed_cmd);
		r.dir = speed_cmd > 0 ? spt_pkg::DIR_FORWARD
			: (speed_cmd < 0 ? spt_pkg::DIR_REVERSE : spt_pkg::DIR_STOP);
		r.duty = 8'(speed_cmd < 0 ? -speed_cmd : speed_cmd);
		r.pwr = motor_on;
		r.loop = loop_on;
		r.trip = trip_q;
		r.err = 11'(err);
		return r;
	endfunction

	function automatic void check_field(string what, integer want, integer got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				status_q.push_back(servo_step(on_bus));
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (sample_q.size() > 0 && (no_idle || $urandom_range(99) >= 9)) begin
					on_bus = sample_q.pop_front();
					in_valid <= 1'b1;
					elapsed_ms <= on_bus.elapsed;
					position_reading <= on_bus.pos;
					current_reading <= on_bus.cur;
					supply_reading <= on_bus.sup;
					target_request <= on_bus.tgt;
					control_request <= on_bus.ctl;
					power_request <= on_bus.pwr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Status monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					$display("%0t: status transaction with none expected, speed %0d err %0d",
						$time, drive_speed, position_error);
					mismatches++;
				end else begin
					want_stat = status_q.pop_front();
					check_field("drive_speed", want_stat.speed, drive_speed);
					check_field("drive_direction", want_stat.dir, drive_direction);
					check_field("drive_duty", want_stat.duty, drive_duty);
					check_field("powered", want_stat.pwr, powered);
					check_field("loop_active", want_stat.loop, loop_active);
					check_field("trip_cause", want_stat.trip, trip_cause);
					check_field("position_error", want_stat.err, position_error);
					results_checked++;
				end
			end
			out_ready <= no_idle || $urandom_range(99) >= 9;
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timeout after %0d cycles, %0d status transactions outstanding",
			cycle_count, status_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic write_reg(spt_pkg::cfg_reg_t idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 20'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			spt_pkg::REG_PROP_GAIN:     kp_q = val & 16'hFFFF;
			spt_pkg::REG_INTEG_GAIN:    ki_q = val & 16'hFFFF;
			spt_pkg::REG_DERIV_GAIN:    kd_q = val & 16'hFFFF;
			spt_pkg::REG_DEAD_ZONE:     dz_q = val & 10'h3FF;
			spt_pkg::REG_LOWEST_POS:    lo_q = val & 10'h3FF;
			spt_pkg::REG_HIGHEST_POS:   hi_q = val & 10'h3FF;
			spt_pkg::REG_CURRENT_CEIL:  ceil_q = val & 10'h3FF;
			spt_pkg::REG_SUPPLY_WINDOW: win_q = val & 20'hFFFFF;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic configure(int kp, int ki, int kd, int dz, int lo, int hi, int ceil, int win);
		write_reg(spt_pkg::REG_PROP_GAIN, kp);
		write_reg(spt_pkg::REG_INTEG_GAIN, ki);
		write_reg(spt_pkg::REG_DERIV_GAIN, kd);
		write_reg(spt_pkg::REG_DEAD_ZONE, dz);
		write_reg(spt_pkg::REG_LOWEST_POS, lo);
		write_reg(spt_pkg::REG_HIGHEST_POS, hi);
		write_reg(spt_pkg::REG_CURRENT_CEIL, ceil);
		write_reg(spt_pkg::REG_SUPPLY_WINDOW, win);
	endtask

	task automatic push_sample(int el, int pos, int cur, int sup, int tgt, bit ctl, bit pwr);
		sample_t s;
		s.elapsed = 16'(el);
		s.pos = 10'(pos);
		s.cur = 10'(cur);
		s.sup = 10'(sup);
		s.tgt = 10'(tgt);
		s.ctl = ctl;
		s.pwr = pwr;
		sample_q.push_back(s);
		items_queued++;
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || status_q.size() != 0)
			@(negedge clk);
	endtask

	// Mostly power-up / enable / run bursts with readings inside the limits;
	// a few bursts are pure noise and runs get dropouts and stray trips.
	task automatic queue_bursts(int n);
		int left, len, k, aim, posv, smin, smax, cur, sup, el;
		bit p, c, noise;
		left = n;
		while (left > 0) begin
			noise = ($urandom_range(9) == 0);
			len = noise ? $urandom_range(10, 1) : $urandom_range(70, 20);
			aim = $urandom_range(1023);
			smin = win_q % 1024;
			smax = win_q / 1024;
			for (k = 0; k < len; k++) begin
				if (noise) begin
					push_sample($urandom_range(65535), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				end else begin
					p = (k != 0);
					c = (k >= 2);
					if ($urandom_range(49) == 0)
						c = 0;
					if ($urandom_range(79) == 0) begin
						p = 0;
						c = 0;
					end
					if ($urandom_range(11) == 0)
						aim = $urandom_range(1023);
					posv = aim + int'($urandom_range(120)) - 60;
					if ($urandom_range(7) == 0)
						posv = $urandom_range(1023);
					if (posv < 0)
						posv = 0;
					if (posv > 1023)
						posv = 1023;
					cur = ($urandom_range(99) == 0) ? $urandom_range(1023)
						: $urandom_range(ceil_q, 0);
					sup = (smin > smax || $urandom_range(99) == 0) ? $urandom_range(1023)
						: $urandom_range(smax, smin);
					el = ($urandom_range(29) == 0) ? $urandom_range(65535) : $urandom_range(25);
					push_sample(el, posv, cur, sup, aim, c, p);
				end
			end
			left -= len;
		end
	endtask

	initial begin
		int ph;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: edges, deadband, saturation, trip and re-arm under reset settings
		push_sample(0, 0, 0, 0, 0, 0, 0);
		push_sample(16'hFFFF, 1023, 1023, 1023, 1023, 1, 0);
		push_sample(1, 0, 0, 0, 1023, 0, 0);
		push_sample(7, 500, 50, 600, 512, 1, 1);
		push_sample(5, 500, 50, 600, 512, 1, 1);
		push_sample(5, 500, 50, 600, 512, 1, 1);
		push_sample(20, 510, 50, 600, 512, 1, 1);
		push_sample(12, 1023, 50, 600, 0, 1, 1);
		push_sample(16'hFFFF, 0, 50, 600, 1023, 1, 1);
		push_sample(3, 0, 50, 600, 1023, 1, 1);
		push_sample(16'hFFFF, 0, 50, 600, 1023, 1, 1);
		push_sample(15, 0, 50, 600, 1023, 0, 1);
		push_sample(50, 300, 50, 600, 800, 1, 1);
		push_sample(10, 300, 50, 600, 800, 1, 1);
		push_sample(10, 300, 103, 600, 800, 1, 1);
		push_sample(10, 300, 0, 600, 800, 1, 1);
		push_sample(10, 300, 0, 600, 800, 0, 0);
		push_sample(10, 300, 0, 600, 800, 0, 1);
		push_sample(10, 520, 102, 600, 512, 1, 1);
		push_sample(10, 520, 50, 600, 512, 1, 1);
		push_sample(10, 520, 50, 600, 512, 1, 0);
		push_sample(10, 520, 50, 600, 512, 1, 1);
		wait_drained();

		configure(512, 64, 32, 3, 100, 900, 500, {10'd800, 10'd200});
		queue_bursts(230);
		wait_drained();

		configure(65535, 65535, 65535, 0, 0, 1023, 1023, 20'hFFFFF);
		queue_bursts(230);
		wait_drained();

		// crossed target bounds, zero gains, widest dead zone, zero ceiling and supply window
		configure(0, 0, 0, 1023, 600, 300, 0, 0);
		queue_bursts(150);
		wait_drained();

		for (ph = 0; ph < 5; ph++) begin
			no_idle = (ph == 2);
			configure($urandom_range(4096), $urandom_range(1024), $urandom_range(2048),
				$urandom_range(12), $urandom_range(300), $urandom_range(1023, 700),
				$urandom_range(1023, 60),
				{10'($urandom_range(1023, 700)), 10'($urandom_range(250))});
			queue_bursts(250);
			wait_drained();
		end
		no_idle = 0;

		repeat (60) @(posedge clk);
		$display("Covered %0d samples and %0d register writes; %0d status transactions checked.",
			items_taken, cfg_writes, results_checked);
		$display("PID steps %0d (%0d saturated), safety trips %0d, mismatches %0d.",
			pid_steps, sat_steps, trips_seen, mismatches);
		if (mismatches == 0 && status_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
